// ----- design/rse_pkg.sv -----
// shared types, constants and codes of the rpn stack evaluator
package rse_pkg;

	localparam int STACK_DEPTH   = 128;
	localparam int FRACTION_BITS = 16;
	localparam int DATA_W        = 32;
	localparam int OP_W          = 3;
	localparam int DEPTH_W       = 8;
	localparam int ADDR_W        = $clog2(STACK_DEPTH);
	localparam int SP_W          = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W         = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	// token codes, anything else is unknown
	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_MUL    = 3'd3,
		OP_DIV    = 3'd4,
		OP_FINISH = 3'd5
	} token_op_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage

// ----- design/rpn_stack_evaluator_core.sv -----
// top level of the rpn stack evaluator: token sequencer, value stack and shared unit
//
// usage
// - input channel (in_valid, in_stall, operation, operand) carries one token per
//   transaction; in_stall is high from the accepting edge until the token is done
// - output channel (out_valid, out_stall, value and flags, depth) returns exactly
//   one transaction per token, held in an output register while stalled
// - a new token is taken while the previous result still waits in the output
//   register; only a second finished result waits for out_stall to drop
// - multiply and divide walk one bit per cycle through the shared unit (32 steps)
// - stack lives in a ram with one write port, one read port and registered read;
//   each pop goes through the registered read port, the push through the write port
// - reset clears the stack pointer, sequencer and output valid; stack contents
//   need no clearing since only written entries are ever popped
// - depth reports the entry count after the token
module rpn_stack_evaluator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rse_pkg::OP_W-1:0]         operation,
	input  logic signed [rse_pkg::DATA_W-1:0] operand,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rse_pkg::DATA_W-1:0] value,
	output logic                             underflow,
	output logic                             overflow,
	output logic                             zero_divide,
	output logic                             unknown_op,
	output logic [rse_pkg::DEPTH_W-1:0]      depth
);
	import rse_pkg::*;

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,  // waiting for a token
		S_POPB = 7'b0000010,  // read top entry (right operand)
		S_GETB = 7'b0000100,  // capture right operand, maybe read left
		S_GETA = 7'b0001000,  // capture left operand, start the unit
		S_CALC = 7'b0010000,  // shared unit busy
		S_PUSH = 7'b0100000,  // write the result back
		S_DONE = 7'b1000000   // hand the result to the output register
	} seq_state_t;

	seq_state_t        state_q;
	logic [SP_W-1:0]   sp_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W-1:0] b_q;
	logic              hit_q;   // last pop came from the ram
	logic              under_q;
	logic              over_q;
	logic              zdiv_q;
	logic              unk_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] value_q;
	logic              underflow_q;
	logic              overflow_q;
	logic              zero_divide_q;
	logic              unknown_op_q;
	logic [DEPTH_W-1:0] depth_q;

	logic [SP_W-1:0]   sp_dec;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] popped;
	logic              ram_we;
	logic              do_pop;
	logic              b_last;  // no second pop after the right operand
	logic              out_load;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	// stack top always sits at sp - 1, so the read address follows the pointer
	assign sp_dec = sp_q - SP_W'(1);
	assign popped = hit_q ? ram_rdata : '0;

	assign b_last = (op_q == OP_FINISH) || ((op_q == OP_DIV) && (popped == '0));
	assign do_pop = (state_q == S_POPB) || ((state_q == S_GETB) && !b_last);
	assign ram_we = (state_q == S_PUSH) && (sp_q < SP_W'(STACK_DEPTH));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != S_IDLE);

	// token code to shared unit operation
	always_comb begin
		alu_req.start = (state_q == S_GETA);
		unique case (op_q)
			OP_ADD:  alu_req.op = ALU_ADD;
			OP_SUB:  alu_req.op = ALU_SUB;
			OP_MUL:  alu_req.op = ALU_MUL;
			default: alu_req.op = ALU_DIV;
		endcase
	end

	rse_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sp_q[ADDR_W-1:0]),
		.wdata (result_q),
		.raddr (sp_dec[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	rse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (popped),
		.b      (b_q),
		.rsp    (alu_rsp)
	);

	// sequencer and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '0;
			op_q     <= '0;
			result_q <= '0;
			b_q      <= '0;
			hit_q    <= 1'b0;
			under_q  <= 1'b0;
			over_q   <= 1'b0;
			zdiv_q   <= 1'b0;
			unk_q    <= 1'b0;
		end else begin
			// pop: empty stack yields zero and flags underflow
			if (do_pop) begin
				if (sp_q != '0) begin
					sp_q  <= sp_dec;
					hit_q <= 1'b1;
				end else begin
					hit_q   <= 1'b0;
					under_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= operation;
						result_q <= operand;
						under_q  <= 1'b0;
						over_q   <= 1'b0;
						zdiv_q   <= 1'b0;
						unk_q    <= 1'b0;
						unique case (operation)
							OP_PUSH: begin
								state_q <= S_PUSH;
							end
							OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_FINISH: begin
								state_q <= S_POPB;
							end
							default: begin
								unk_q    <= 1'b1;
								result_q <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_POPB: begin
					state_q <= S_GETB;
				end
				S_GETB: begin
					b_q <= popped;
					if (op_q == OP_FINISH) begin
						result_q <= popped;
						state_q  <= S_DONE;
					end else if (b_last) begin
						// zero divisor: discarded, dividend stays, nothing pushed
						zdiv_q   <= 1'b1;
						result_q <= '0;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_GETA;
					end
				end
				S_GETA: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (alu_rsp.done) begin
						result_q <= alu_rsp.result;
						state_q  <= S_PUSH;
					end
				end
				S_PUSH: begin
					// full stack drops the value
					if (ram_we) begin
						sp_q <= sp_q + SP_W'(1);
					end else begin
						over_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register, frees the sequencer while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q       <= result_q;
			underflow_q   <= under_q;
			overflow_q    <= over_q;
			zero_divide_q <= zdiv_q;
			unknown_op_q  <= unk_q;
			depth_q       <= DEPTH_W'(sp_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign underflow   = underflow_q;
	assign overflow    = overflow_q;
	assign zero_divide = zero_divide_q;
	assign unknown_op  = unknown_op_q;
	assign depth       = depth_q;

`ifndef SYNTH
	// one token at a time: the sequencer closes the input right after a transaction
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("token accepted while another is in flight");

	// stack pointer never runs past the stack
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// shared unit only finishes while the sequencer waits for it
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_CALC)
		else $error("shared unit result with no waiting sequencer");

	// overflow only reported when the stack is full
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && over_q |-> sp_q == SP_W'(STACK_DEPTH))
		else $error("overflow flagged with room on the stack");

	// a zero divisor result carries a zero value and pushes nothing
	a_zdiv_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_divide_q |-> value_q == '0 && !overflow_q)
		else $error("zero divide result not clean");
`endif

endmodule

// ----- design/rse_ram.sv -----
// generic single write port ram with registered read
module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/rse_alu.sv -----
// shared iterative fixed point unit: add, subtract, shift-add multiply, restoring divide
module rse_alu (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rse_pkg::alu_req_t       req,
	input  logic [rse_pkg::DATA_W-1:0] a,
	input  logic [rse_pkg::DATA_W-1:0] b,
	output rse_pkg::alu_rsp_t       rsp
);
	import rse_pkg::*;

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RUN  = 3'b010,
		A_FIN  = 3'b100
	} alu_state_t;

	alu_state_t        state_q;
	alu_op_t           op_q;
	logic              neg_q;
	logic              presat_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] m_q;

	logic [DATA_W-1:0]   mag_a, mag_b;
	logic [2*DATA_W-1:0] wide_a;
	logic [DATA_W+1:0]   add_x, add_y, add_sum;
	logic                add_cin;
	logic                quot_bit;
	logic [2*DATA_W-1:0] prod_shift;
	logic [DATA_W:0]     sum33;
	logic                big;
	logic [DATA_W-1:0]   mag_res;
	logic [DATA_W-1:0]   result;

	assign mag_a  = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign mag_b  = b[DATA_W-1] ? (~b + 1'b1) : b;
	// dividend magnitude scaled by the fraction; high word seeds the remainder
	assign wide_a = {{DATA_W{1'b0}}, mag_a} << FRACTION_BITS;

	// the one adder, operands steered by operation
	always_comb begin
		unique case (op_q)
			ALU_ADD: begin
				add_x   = {{2{lo_q[DATA_W-1]}}, lo_q};
				add_y   = {{2{m_q[DATA_W-1]}}, m_q};
				add_cin = 1'b0;
			end
			ALU_SUB: begin
				add_x   = {{2{lo_q[DATA_W-1]}}, lo_q};
				add_y   = ~{{2{m_q[DATA_W-1]}}, m_q};
				add_cin = 1'b1;
			end
			ALU_MUL: begin
				add_x   = {2'b00, acc_q};
				add_y   = lo_q[0] ? {2'b00, m_q} : '0;
				add_cin = 1'b0;
			end
			ALU_DIV: begin
				add_x   = {1'b0, acc_q, lo_q[DATA_W-1]};
				add_y   = ~{2'b00, m_q};
				add_cin = 1'b1;
			end
			default: begin
				add_x   = '0;
				add_y   = '0;
				add_cin = 1'b0;
			end
		endcase
	end

	assign add_sum  = add_x + add_y + {{(DATA_W+1){1'b0}}, add_cin};
	assign quot_bit = ~add_sum[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						if (req.op == ALU_MUL || req.op == ALU_DIV) begin
							state_q <= A_RUN;
						end else begin
							state_q <= A_FIN;
						end
					end
				end
				A_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DATA_W - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && req.start) begin
			op_q     <= req.op;
			neg_q    <= a[DATA_W-1] ^ b[DATA_W-1];
			presat_q <= 1'b0;
			unique case (req.op)
				ALU_MUL: begin
					acc_q <= '0;
					lo_q  <= mag_a;
					m_q   <= mag_b;
				end
				ALU_DIV: begin
					acc_q    <= wide_a[2*DATA_W-1:DATA_W];
					lo_q     <= wide_a[DATA_W-1:0];
					m_q      <= mag_b;
					// quotient would not fit in one word
					presat_q <= (wide_a[2*DATA_W-1:DATA_W] >= mag_b);
				end
				default: begin
					acc_q <= '0;
					lo_q  <= a;
					m_q   <= b;
				end
			endcase
		end else if (state_q == A_RUN) begin
			if (op_q == ALU_MUL) begin
				acc_q <= add_sum[DATA_W:1];
				lo_q  <= {add_sum[0], lo_q[DATA_W-1:1]};
			end else begin
				acc_q <= quot_bit ? add_sum[DATA_W-1:0] : {acc_q[DATA_W-2:0], lo_q[DATA_W-1]};
				lo_q  <= {lo_q[DATA_W-2:0], quot_bit};
			end
		end
	end

	assign prod_shift = {acc_q, lo_q} >> FRACTION_BITS;
	assign sum33      = add_sum[DATA_W:0];

	always_comb begin
		big     = 1'b0;
		mag_res = lo_q;
		result  = '0;
		unique case (op_q)
			ALU_ADD, ALU_SUB: begin
				if (sum33[DATA_W] ^ sum33[DATA_W-1]) begin
					result = sum33[DATA_W] ? SAT_MIN : SAT_MAX;
				end else begin
					result = sum33[DATA_W-1:0];
				end
			end
			default: begin
				if (op_q == ALU_MUL) begin
					big     = |prod_shift[2*DATA_W-1:DATA_W-1];
					mag_res = prod_shift[DATA_W-1:0];
				end else begin
					big     = presat_q | lo_q[DATA_W-1];
					mag_res = lo_q;
				end
				if (big) begin
					result = neg_q ? SAT_MIN : SAT_MAX;
				end else begin
					result = neg_q ? (~mag_res + 1'b1) : mag_res;
				end
			end
		endcase
	end

	assign rsp.done   = (state_q == A_FIN);
	assign rsp.result = result;

endmodule

// ----- test/rse_result_checker.sv -----
// result checker of the rpn stack evaluator: predicts every token and compares each result
module rse_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [rse_pkg::OP_W-1:0]          operation,
	input  logic signed [rse_pkg::DATA_W-1:0] operand,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [rse_pkg::DATA_W-1:0] value,
	input  logic                              underflow,
	input  logic                              overflow,
	input  logic                              zero_divide,
	input  logic                              unknown_op,
	input  logic [rse_pkg::DEPTH_W-1:0]       depth,
	output int                                fail_count,
	output int                                open_count,
	output int                                result_count,
	output int                                underflow_hits,
	output int                                overflow_hits,
	output int                                zero_divide_hits,
	output int                                unknown_hits
);
	import rse_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0]  value;
		logic               underflow;
		logic               overflow;
		logic               zero_divide;
		logic               unknown_op;
		logic [DEPTH_W-1:0] depth;
	} token_result_t;

	// private copy of the value stack
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	int unsigned       stack_count;
	logic              popped_empty;
	logic              push_dropped;

	token_result_t     pending_results [$];
	token_result_t     want;
	int                mismatches;
	int                checked;
	int                n_under;
	int                n_over;
	int                n_zdiv;
	int                n_unknown;

	function automatic void stack_push(logic [DATA_W-1:0] v);
		if (stack_count < STACK_DEPTH) begin
			stack_mem[ADDR_W'(stack_count)] = v;
			stack_count++;
		end else
			push_dropped = 1'b1;
	endfunction

	function automatic logic [DATA_W-1:0] stack_pop();
		if (stack_count > 0) begin
			stack_count--;
			return stack_mem[ADDR_W'(stack_count)];
		end
		popped_empty = 1'b1;
		return '0;
	endfunction

	function automatic logic [DATA_W-1:0] clamp_sum(longint s);
		if (s > 64'sh7FFF_FFFF)
			return SAT_MAX;
		if (s < -64'sh8000_0000)
			return SAT_MIN;
		return DATA_W'(s);
	endfunction

	function automatic logic [63:0] magnitude_of(logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] m;
		m = x[DATA_W-1] ? (~x + 1'b1) : x;
		return 64'(m);
	endfunction

	// sign a magnitude and clamp it into the 32-bit range
	function automatic logic [DATA_W-1:0] signed_clamp(logic [63:0] mag, logic neg);
		if (neg)
			return (mag >= 64'h8000_0000) ? SAT_MIN : DATA_W'(64'd0 - mag);
		return (mag > 64'h7FFF_FFFF) ? SAT_MAX : DATA_W'(mag);
	endfunction

	function automatic token_result_t rpn_evaluate(logic [OP_W-1:0] op, logic [DATA_W-1:0] arg);
		token_result_t     r;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] res;
		r            = '0;
		res          = '0;
		popped_empty = 1'b0;
		push_dropped = 1'b0;
		case (op)
			OP_PUSH: begin
				res = arg;
				stack_push(res);
			end
			OP_ADD, OP_SUB: begin
				rhs = stack_pop();
				lhs = stack_pop();
				if (op == OP_ADD)
					res = clamp_sum(longint'($signed(lhs)) + longint'($signed(rhs)));
				else
					res = clamp_sum(longint'($signed(lhs)) - longint'($signed(rhs)));
				stack_push(res);
			end
			OP_MUL: begin
				rhs = stack_pop();
				lhs = stack_pop();
				res = signed_clamp((magnitude_of(lhs) * magnitude_of(rhs)) >> FRACTION_BITS,
					lhs[DATA_W-1] ^ rhs[DATA_W-1]);
				stack_push(res);
			end
			OP_DIV: begin
				rhs = stack_pop();
				// a zero divisor is discarded and the dividend stays put
				if (rhs == '0)
					r.zero_divide = 1'b1;
				else begin
					lhs = stack_pop();
					res = signed_clamp((magnitude_of(lhs) << FRACTION_BITS) / magnitude_of(rhs),
						lhs[DATA_W-1] ^ rhs[DATA_W-1]);
					stack_push(res);
				end
			end
			OP_FINISH: begin
				res = stack_pop();
			end
			default: begin
				r.unknown_op = 1'b1;
			end
		endcase
		r.value     = res;
		r.underflow = popped_empty;
		r.overflow  = push_dropped;
		r.depth     = DEPTH_W'(stack_count);
		return r;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
		logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count = 0;
			pending_results.delete();
		end else begin
			// results first: a result never belongs to a token taken at the same edge
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no token outstanding: value %0h, depth %0d", value, depth);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					checked++;
					check_field("value", want.value, value);
					check_field("underflow", DATA_W'(want.underflow), DATA_W'(underflow));
					check_field("overflow", DATA_W'(want.overflow), DATA_W'(overflow));
					check_field("zero_divide", DATA_W'(want.zero_divide),
						DATA_W'(zero_divide));
					check_field("unknown_op", DATA_W'(want.unknown_op), DATA_W'(unknown_op));
					check_field("depth", DATA_W'(want.depth), DATA_W'(depth));
					n_under   += int'(want.underflow);
					n_over    += int'(want.overflow);
					n_zdiv    += int'(want.zero_divide);
					n_unknown += int'(want.unknown_op);
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(rpn_evaluate(operation, operand));
		end
		fail_count       <= mismatches;
		open_count       <= pending_results.size();
		result_count     <= checked;
		underflow_hits   <= n_under;
		overflow_hits    <= n_over;
		zero_divide_hits <= n_zdiv;
		unknown_hits     <= n_unknown;
	end

endmodule

// ----- test/rpn_stack_evaluator_core_tb.sv -----
// testbench top of the rpn stack evaluator: token stimulus, output stalls and verdict
module rpn_stack_evaluator_core_tb;
	import rse_pkg::*;

	// token count of the random part, watchdog limit and settle time at the end
	localparam int TOKEN_TARGET = 1250;
	localparam int IDLE_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 60;

	// the two codes the block does not recognize
	localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [OP_W-1:0]           operation;
	logic signed [DATA_W-1:0]  operand;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  value;
	logic                      underflow;
	logic                      overflow;
	logic                      zero_divide;
	logic                      unknown_op;
	logic [DEPTH_W-1:0]        depth;

	// figures handed up by the checker
	int fail_count;
	int open_count;
	int result_count;
	int underflow_hits;
	int overflow_hits;
	int zero_divide_hits;
	int unknown_hits;

	int tokens_sent;
	int op_tally [8];
	int quiet_tokens;
	int stall_hold;
	int stall_roll;
	int idle_cycles;
	int fill_bursts;

	rpn_stack_evaluator_core uut (.*);

	rse_result_checker result_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// output stall pattern: short random toggling, some long stalls, and
	// stretches where the output never stalls
	always @(posedge clk) begin
		if (stall_hold > 0)
			stall_hold <= stall_hold - 1;
		else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 12) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(100, 300);
			end else if (stall_roll < 55) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 3);
			end else if (stall_roll < 92) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$error("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// idle cycles in front of the next token; quiet runs send back to back
	function automatic int next_gap();
		int roll;
		if (quiet_tokens > 0) begin
			quiet_tokens--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			quiet_tokens = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one token transaction; valid and payload hold until the block takes them
	task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] arg);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		operand   <= arg;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		tokens_sent++;
		op_tally[op]++;
	endtask

	// operands lean on the extremes, zero and small whole values so that
	// saturation and zero divisors come up often
	function automatic logic [DATA_W-1:0] random_operand();
		logic [DATA_W-1:0] whole;
		whole = DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
		case ($urandom_range(0, 7))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return '0;
			3, 4: return {whole[DATA_W-FRACTION_BITS-1:0], FRACTION_BITS'($urandom)};
			5: return {whole[DATA_W-FRACTION_BITS-1:0], FRACTION_BITS'(0)};
			default: return $urandom;
		endcase
	endfunction

	function automatic token_op_t random_operator(bit with_finish);
		case ($urandom_range(0, with_finish ? 4 : 3))
			0: return OP_ADD;
			1: return OP_SUB;
			2: return OP_MUL;
			3: return OP_DIV;
			default: return OP_FINISH;
		endcase
	endfunction

	// a well-formed postfix expression over a few operands, closed by finish
	// unless it is meant to leave its value on the stack
	task automatic send_expression(input int operands, input bit closed);
		int on_stack;
		int pushes_left;
		int ops_left;
		on_stack    = 0;
		pushes_left = operands;
		ops_left    = operands - 1;
		while (pushes_left > 0 || ops_left > 0) begin
			if (on_stack >= 2 && ops_left > 0 &&
				(pushes_left == 0 || $urandom_range(0, 1) == 1)) begin
				send_token(random_operator(1'b0), $urandom);
				ops_left--;
				on_stack--;
			end else begin
				send_token(OP_PUSH, random_operand());
				pushes_left--;
				on_stack++;
			end
		end
		if (closed)
			send_token(OP_FINISH, $urandom);
	endtask

	// fill past full from any depth, then pop past empty
	task automatic fill_and_drain();
		repeat (STACK_DEPTH + 4) send_token(OP_PUSH, random_operand());
		repeat (STACK_DEPTH + 8) send_token(random_operator(1'b1), $urandom);
	endtask

	task automatic run_directed();
		// pops from an empty stack, alone and in pairs
		send_token(OP_FINISH, '0);
		send_token(OP_ADD, '1);
		// zero divisor on the stack, then divide on an empty stack
		send_token(OP_DIV, '0);
		send_token(OP_DIV, '0);
		send_token(OP_UNKNOWN_LO, SAT_MIN);
		send_token(OP_UNKNOWN_HI, SAT_MAX);
		// sums and differences clamped at both ends
		send_token(OP_PUSH, SAT_MAX);
		send_token(OP_PUSH, SAT_MAX);
		send_token(OP_ADD, '0);
		send_token(OP_PUSH, SAT_MIN);
		send_token(OP_SUB, '0);
		send_token(OP_PUSH, SAT_MIN);
		send_token(OP_PUSH, SAT_MIN);
		send_token(OP_ADD, '0);
		// most negative squared, then max squared
		send_token(OP_PUSH, SAT_MIN);
		send_token(OP_MUL, '0);
		send_token(OP_MUL, '0);
		// divide by one half clamps, times minus one, divide by three
		send_token(OP_PUSH, 32'h0000_8000);
		send_token(OP_DIV, '0);
		send_token(OP_PUSH, 32'hFFFF_0000);
		send_token(OP_MUL, '0);
		send_token(OP_PUSH, 32'h0003_0000);
		send_token(OP_DIV, '0);
		send_token(OP_FINISH, '0);
		// binary operator with a single operand on the stack
		send_token(OP_PUSH, 32'hFFFF_FFFF);
		send_token(OP_MUL, '0);
		send_token(OP_FINISH, '0);
	endtask

	task automatic run_random();
		int roll;
		while (tokens_sent < TOKEN_TARGET) begin
			if (fill_bursts < 2 && tokens_sent >= 350 + 450 * fill_bursts) begin
				fill_and_drain();
				fill_bursts++;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					send_expression($urandom_range(1, 6), 1'b1);
				else if (roll < 85)
					// noise: any code, unknown ones included
					repeat ($urandom_range(1, 4)) send_token(OP_W'($urandom), $urandom);
				else begin
					// broken expression: finish may be missing, extra operators follow
					send_expression($urandom_range(1, 4), 1'($urandom_range(0, 1)));
					repeat ($urandom_range(1, 2)) send_token(random_operator(1'b0), $urandom);
				end
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_PUSH;
		operand      = '0;
		out_stall    = 1'b0;
		stall_hold   = 0;
		idle_cycles  = 0;
		quiet_tokens = 0;
		tokens_sent  = 0;
		fill_bursts  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random();
		in_valid <= 1'b0;

		// wait for every outstanding result, then let any stray one show up
		do
			@(posedge clk);
		while (open_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tokens %0d: push %0d add %0d sub %0d mul %0d div %0d finish %0d unknown %0d",
			tokens_sent, op_tally[OP_PUSH], op_tally[OP_ADD], op_tally[OP_SUB],
			op_tally[OP_MUL], op_tally[OP_DIV], op_tally[OP_FINISH],
			op_tally[OP_UNKNOWN_LO] + op_tally[OP_UNKNOWN_HI]);
		$display("results %0d: underflow %0d overflow %0d zero divide %0d unknown op %0d",
			result_count, underflow_hits, overflow_hits, zero_divide_hits, unknown_hits);
		if (fail_count == 0 && open_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
